[hdl/ptta_pkg.sv]
`default_nettype none

package ptta_pkg;

  // action codes of an input item; the unused code acts as a lookup
  typedef enum logic [1:0] {
    ACT_OBSERVE = 2'd0,
    ACT_TICK    = 2'd1,
    ACT_LOOKUP  = 2'd2
  } action_e;

  // result status codes
  localparam logic [2:0] ST_UPDATED   = 3'd0;
  localparam logic [2:0] ST_INSERTED  = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_AGED      = 3'd3;
  localparam logic [2:0] ST_TICK_NOAGE = 3'd4;
  localparam logic [2:0] ST_TICK_SKIP = 3'd5;
  localparam logic [2:0] ST_FOUND     = 3'd6;
  localparam logic [2:0] ST_NOT_FOUND = 3'd7;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_AIRPLANE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_TTL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TTL      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPECIAL_CODE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNSET_CODE   = 3'd4;

  typedef struct packed {
    logic       airplane;
    logic [7:0] initial_ttl;
    logic [7:0] max_ttl;
    logic [3:0] special_code;
    logic [3:0] unset_code;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] peer_id;
    logic [3:0]  cur_kind;
    logic [3:0]  base_kind;
    logic        fighting;
  } item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] slot;
    logic [7:0] ttl;
    logic [3:0] cur_kind;
    logic [3:0] base_kind;
    logic       fighting;
    logic [4:0] elig;
    logic       special;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic scan;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
  } sts_t;

endpackage

`default_nettype wire

[hdl/ptta_ctrl.sv]
`default_nettype none

module ptta_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            out_free_i,
  input  ptta_pkg::sts_t  sts_i,
  output ptta_pkg::cmd_t  cmd_o,
  output logic            idle_o
);
  import ptta_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    idle_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        idle_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free_i) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[hdl/ptta_dp.sv]
`default_nettype none

module ptta_dp #(
  parameter int unsigned ENTRIES  = 16,
  parameter int unsigned ID_BITS  = 32,
  parameter int unsigned TTL_BITS = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ptta_pkg::cmd_t  cmd_i,
  output ptta_pkg::sts_t  sts_o,
  input  ptta_pkg::item_t item_i,
  input  ptta_pkg::cfg_t  cfg_i,
  output ptta_pkg::res_t  res_o
);
  import ptta_pkg::*;

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  typedef struct packed {
    logic [ID_BITS-1:0]  id;
    logic [TTL_BITS-1:0] life;
    logic [3:0]          cur_kind;
    logic [3:0]          base_kind;
    logic                fighting;
  } ent_t;

  // item and control registers
  item_t              item_q;
  logic               do_age_q;
  logic [2:0]         tick_status_q;
  logic               phase_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               p_vld_q;
  logic [IDX_W-1:0]   p_idx_q;
  logic [ENTRIES-1:0] valid_q;
  logic               hit_q;
  logic               free_q;

  // scan results
  ent_t               rd_q;
  ent_t               hit_ent_q;
  logic [IDX_W-1:0]   hit_idx_q;
  logic [IDX_W-1:0]   free_idx_q;
  logic [CNT_W-1:0]   elig_q;
  logic [CNT_W-1:0]   spec_q;
  logic               old_elig_q;
  logic               old_spec_q;

  // entry store
  ent_t               mem_q [ENTRIES];

  logic                 scan_rd;
  logic [IDX_W-1:0]     rd_idx;
  logic                 is_obs;
  logic                 is_tick;
  logic [ID_BITS+31:0]  id_ext;
  logic [ID_BITS-1:0]   id_in;
  logic [TTL_BITS+7:0]  init_ext;
  logic [TTL_BITS+7:0]  max_ext;
  logic [TTL_BITS-1:0]  init_life;
  logic [TTL_BITS-1:0]  top_life;
  logic [TTL_BITS-1:0]  bump_life;
  logic                 v;
  logic                 kill;
  logic                 post_v;
  logic                 c_elig;
  logic                 c_spec;
  logic                 match;
  logic                 new_elig;
  logic                 new_spec;
  logic                 we;
  logic [IDX_W-1:0]     wa;
  ent_t                 wd;
  logic                 ins;

  assign scan_rd = cmd_i.scan && (cnt_q != CNT_W'(ENTRIES));
  assign rd_idx  = cnt_q[IDX_W-1:0];
  assign sts_o.scan_done = (cnt_q == CNT_W'(ENTRIES));

  assign is_obs  = (item_q.action == ACT_OBSERVE);
  assign is_tick = (item_q.action == ACT_TICK);

  // field widths of the table
  assign id_ext    = {{ID_BITS{1'b0}}, item_q.peer_id};
  assign id_in     = id_ext[ID_BITS-1:0];
  assign init_ext  = {{TTL_BITS{1'b0}}, cfg_i.initial_ttl};
  assign max_ext   = {{TTL_BITS{1'b0}}, cfg_i.max_ttl};
  assign init_life = init_ext[TTL_BITS-1:0];
  assign top_life  = max_ext[TTL_BITS-1:0];
  assign bump_life = ((hit_ent_q.life < top_life) && (hit_ent_q.life != '1))
                     ? hit_ent_q.life + TTL_BITS'(1) : hit_ent_q.life;

  // per entry evaluation of the scanned word
  assign v      = valid_q[p_idx_q];
  assign kill   = (rd_q.life <= TTL_BITS'(1));
  assign post_v = do_age_q ? (v && !kill) : v;
  assign c_elig = post_v && !rd_q.fighting && (rd_q.base_kind != cfg_i.unset_code);
  assign c_spec = post_v && (rd_q.cur_kind == cfg_i.special_code);
  assign match  = v && (rd_q.id == id_in);

  // contribution of the observed peer
  assign new_elig = !item_q.fighting && (item_q.base_kind != cfg_i.unset_code);
  assign new_spec = (item_q.cur_kind == cfg_i.special_code);

  assign ins = cmd_i.commit && is_obs && !hit_q && free_q;

  // store write port: commit of an observe or aging write-back
  always_comb begin
    we = 1'b0;
    wa = p_idx_q;
    wd = rd_q;
    if (cmd_i.commit && is_obs && (hit_q || free_q)) begin
      we           = 1'b1;
      wa           = hit_q ? hit_idx_q : free_idx_q;
      wd.id        = id_in;
      wd.life      = hit_q ? bump_life : init_life;
      wd.cur_kind  = item_q.cur_kind;
      wd.base_kind = item_q.base_kind;
      wd.fighting  = item_q.fighting;
    end else if (p_vld_q && do_age_q && v && !kill) begin
      we      = 1'b1;
      wd.life = rd_q.life - TTL_BITS'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    if (scan_rd) begin
      rd_q <= mem_q[rd_idx];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      cnt_q   <= '0;
      p_vld_q <= 1'b0;
      valid_q <= '0;
      hit_q   <= 1'b0;
      free_q  <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        cnt_q   <= '0;
        p_vld_q <= 1'b0;
        hit_q   <= 1'b0;
        free_q  <= 1'b0;
        if ((item_i.action == ACT_TICK) && !cfg_i.airplane) begin
          phase_q <= ~phase_q;
        end
      end else begin
        p_vld_q <= scan_rd;
        if (scan_rd) begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end
      if (p_vld_q) begin
        if (match && !hit_q) begin
          hit_q <= 1'b1;
        end
        if (!v && !free_q) begin
          free_q <= 1'b1;
        end
        if (do_age_q && v && kill) begin
          valid_q[p_idx_q] <= 1'b0;
        end
      end
      if (ins) begin
        valid_q[free_idx_q] <= 1'b1;
      end
    end
  end

  // item capture and scan accumulation
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      item_q   <= item_i;
      do_age_q <= (item_i.action == ACT_TICK) && !cfg_i.airplane && phase_q;
      if (cfg_i.airplane) begin
        tick_status_q <= ST_TICK_SKIP;
      end else if (phase_q) begin
        tick_status_q <= ST_AGED;
      end else begin
        tick_status_q <= ST_TICK_NOAGE;
      end
      elig_q <= '0;
      spec_q <= '0;
    end
    if (scan_rd) begin
      p_idx_q <= rd_idx;
    end
    if (p_vld_q) begin
      elig_q <= elig_q + CNT_W'(c_elig);
      spec_q <= spec_q + CNT_W'(c_spec);
      if (match && !hit_q) begin
        hit_idx_q  <= p_idx_q;
        hit_ent_q  <= rd_q;
        old_elig_q <= c_elig;
        old_spec_q <= c_spec;
      end
      if (!v && !free_q) begin
        free_idx_q <= p_idx_q;
      end
    end
  end

  // result assembly
  logic [CNT_W:0]      elig_fin;
  logic [CNT_W:0]      spec_fin;
  logic [CNT_W+5:0]    elig_ext;
  logic [IDX_W+3:0]    slot_ext;
  logic [TTL_BITS+7:0] ttl_ext;
  logic [IDX_W-1:0]    res_idx;
  logic [TTL_BITS-1:0] res_life;
  logic                show_ent;

  always_comb begin
    elig_fin = {1'b0, elig_q};
    spec_fin = {1'b0, spec_q};
    res_idx  = hit_idx_q;
    res_life = hit_ent_q.life;
    show_ent = 1'b0;
    res_o    = '0;
    if (is_obs) begin
      if (hit_q) begin
        res_o.status = ST_UPDATED;
        elig_fin = {1'b0, elig_q} + (CNT_W+1)'(new_elig) - (CNT_W+1)'(old_elig_q);
        spec_fin = {1'b0, spec_q} + (CNT_W+1)'(new_spec) - (CNT_W+1)'(old_spec_q);
        res_life = bump_life;
        show_ent = 1'b1;
      end else if (free_q) begin
        res_o.status = ST_INSERTED;
        elig_fin = {1'b0, elig_q} + (CNT_W+1)'(new_elig);
        spec_fin = {1'b0, spec_q} + (CNT_W+1)'(new_spec);
        res_idx  = free_idx_q;
        res_life = init_life;
        show_ent = 1'b1;
      end else begin
        res_o.status = ST_FULL;
      end
    end else if (is_tick) begin
      res_o.status = tick_status_q;
    end else begin
      res_o.status = hit_q ? ST_FOUND : ST_NOT_FOUND;
      show_ent     = hit_q;
    end
    slot_ext = {4'b0, res_idx};
    ttl_ext  = {8'b0, res_life};
    elig_ext = {5'b0, elig_fin};
    if (show_ent) begin
      res_o.slot = slot_ext[3:0];
      res_o.ttl  = ttl_ext[7:0];
      if (is_obs) begin
        res_o.cur_kind  = item_q.cur_kind;
        res_o.base_kind = item_q.base_kind;
        res_o.fighting  = item_q.fighting;
      end else begin
        res_o.cur_kind  = hit_ent_q.cur_kind;
        res_o.base_kind = hit_ent_q.base_kind;
        res_o.fighting  = hit_ent_q.fighting;
      end
    end
    res_o.elig    = (elig_ext > (CNT_W+6)'(31)) ? 5'd31 : elig_ext[4:0];
    res_o.special = (spec_fin != '0);
  end

endmodule

`default_nettype wire

[hdl/peer_table_ttl_aging.sv]
// an item scans all entries; its result is committed once the output is free
// the input stalls until the result is committed; the scan reads one entry
//   per cycle over the single read port of the entry store
// a finished result waits in the output register while the next item scans
// reset: all entries invalid, aging phase zero, registers at their defaults
`default_nettype none

module peer_table_ttl_aging #(
  parameter int unsigned ENTRIES  = 16,
  parameter int unsigned ID_BITS  = 32,
  parameter int unsigned TTL_BITS = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ptta_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ptta_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         action_i,
  input  logic [31:0]                        peer_id_i,
  input  logic [3:0]                         current_kind_i,
  input  logic [3:0]                         base_kind_i,
  input  logic                               fighting_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [2:0]                         status_o,
  output logic [3:0]                         slot_o,
  output logic [7:0]                         entry_ttl_o,
  output logic [3:0]                         found_current_kind_o,
  output logic [3:0]                         found_base_kind_o,
  output logic                               found_fighting_o,
  output logic [4:0]                         eligible_count_o,
  output logic                               special_nearby_o
);
  import ptta_pkg::*;

  cfg_t  cfg_q;
  item_t item;
  cmd_t  cmd;
  sts_t  sts;
  res_t  res;
  res_t  res_q;
  logic  out_valid_q;
  logic  out_free;
  logic  idle;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.airplane     <= 1'b0;
      cfg_q.initial_ttl  <= 8'd4;
      cfg_q.max_ttl      <= 8'd8;
      cfg_q.special_code <= 4'd1;
      cfg_q.unset_code   <= 4'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_AIRPLANE:     cfg_q.airplane     <= cfg_data_i[0];
        CFG_INITIAL_TTL:  cfg_q.initial_ttl  <= cfg_data_i;
        CFG_MAX_TTL:      cfg_q.max_ttl      <= cfg_data_i;
        CFG_SPECIAL_CODE: cfg_q.special_code <= cfg_data_i[3:0];
        CFG_UNSET_CODE:   cfg_q.unset_code   <= cfg_data_i[3:0];
        default: begin
        end
      endcase
    end
  end

  // input item
  assign item.action    = action_i;
  assign item.peer_id   = peer_id_i;
  assign item.cur_kind  = current_kind_i;
  assign item.base_kind = base_kind_i;
  assign item.fighting  = fighting_i;
  assign in_stall_o     = ~idle;

  assign out_free = ~out_valid_q | ~out_stall_i;

  ptta_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .idle_o     (idle)
  );

  ptta_dp #(
    .ENTRIES  (ENTRIES),
    .ID_BITS  (ID_BITS),
    .TTL_BITS (TTL_BITS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .item_i (item),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.commit) begin
      res_q <= res;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign status_o             = res_q.status;
  assign slot_o               = res_q.slot;
  assign entry_ttl_o          = res_q.ttl;
  assign found_current_kind_o = res_q.cur_kind;
  assign found_base_kind_o    = res_q.base_kind;
  assign found_fighting_o     = res_q.fighting;
  assign eligible_count_o     = res_q.elig;
  assign special_nearby_o     = res_q.special;

endmodule

`default_nettype wire

[hdl/ptta_chk.sv]
`default_nettype none

module ptta_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  status_o,
  input logic [3:0]  slot_o,
  input logic [7:0]  entry_ttl_o,
  input logic [3:0]  found_current_kind_o,
  input logic [3:0]  found_base_kind_o,
  input logic        found_fighting_o
);
  import ptta_pkg::*;

  logic no_entry;
  assign no_entry = (slot_o == 4'd0) && (entry_ttl_o == 8'd0) &&
                    (found_current_kind_o == 4'd0) && (found_base_kind_o == 4'd0) &&
                    !found_fighting_o;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(slot_o))
    else $error("stalled result changed");

  // an accepted item keeps the input stalled while it scans
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after transfer");

  // a full table reports no entry
  a_full_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |-> no_entry)
    else $error("full result carries entry fields");

  // ticks report no entry
  a_tick_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((status_o == ST_AGED) || (status_o == ST_TICK_NOAGE) ||
                    (status_o == ST_TICK_SKIP)) |-> no_entry)
    else $error("tick result carries entry fields");

  // a missed lookup reports no entry
  a_miss_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_NOT_FOUND) |-> no_entry)
    else $error("missed lookup carries entry fields");

endmodule

bind peer_table_ttl_aging ptta_chk u_ptta_chk (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_valid_i           (in_valid_i),
  .in_stall_o           (in_stall_o),
  .out_valid_o          (out_valid_o),
  .out_stall_i          (out_stall_i),
  .status_o             (status_o),
  .slot_o               (slot_o),
  .entry_ttl_o          (entry_ttl_o),
  .found_current_kind_o (found_current_kind_o),
  .found_base_kind_o    (found_base_kind_o),
  .found_fighting_o     (found_fighting_o)
);

`default_nettype wire
